@@ hdl/heightmap_barycentric_height_query_assert.svh @@
// ----------------------------------------------------------------------------
// heightmap barycentric height query: assertion macros
// Shared property forms for the checkers of this block.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BARYCENTRIC_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTMAP_BARYCENTRIC_HEIGHT_QUERY_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HBHQ_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define HBHQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hbhq_pkg.sv @@
// ----------------------------------------------------------------------------
// hbhq_pkg
// Types and constants of the heightmap barycentric height query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbhq_pkg;

	localparam int HGT_W = 32;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// 1.0 in Q1.16 weights
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [31:0] INV_CELL_RST = 32'd65536;
	localparam logic [8:0]  SIDE_RST     = 9'd256;
	localparam logic [8:0]  SIDE_MIN     = 9'd2;

	typedef enum logic [1:0] {
		CFG_ORIGIN_X = 2'd0,
		CFG_ORIGIN_Z = 2'd1,
		CFG_INV_CELL = 2'd2,
		CFG_SIDE     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic               req_type;
		logic [15:0]        vertex_index;
		logic signed [31:0] height_value;
		logic signed [31:0] world_x;
		logic signed [31:0] world_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] terrain_height;
		logic               outside_grid;
	} rsp_t;

endpackage

`default_nettype wire

@@ hdl/hbhq_ram.sv @@
// ----------------------------------------------------------------------------
// hbhq_ram
// One height bank: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbhq_ram
	import hbhq_pkg::*;
#(
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [HGT_W-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [HGT_W-1:0]         rdata
);

	logic [HGT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/heightmap_barycentric_height_query.sv @@
// ----------------------------------------------------------------------------
// heightmap_barycentric_height_query
// Height grid store with barycentric height lookup at world x,z points.
// ----------------------------------------------------------------------------
// Use: requests enter on req (req_valid / req_stall). A write request stores
// height_value at vertex_index and returns nothing; a query request returns
// one rsp item (rsp_valid / rsp_stall) with the interpolated height, or
// height 0 and outside_grid set when the point misses the grid.
// Registers are written on cfg_we with cfg_index / cfg_data; the user must
// write them only while idle: the block does not enforce it. Throughput:
// one request per cycle while req_stall is low, writes and queries mixed
// freely. Queries pass a nine-register pipeline (subtract, scale multiply,
// split, address, bank read, corner select, weight multiply, sum, round).
// Each height is kept in two copies, each split into even and odd banks,
// so all four cell corners are read in the same cycle.
// Reset clears the pipeline and loads the register defaults; the height
// store is not cleared, so read only vertices that were written.
// When rsp_stall holds a waiting result the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heightmap_barycentric_height_query
	import hbhq_pkg::*;
#(
	parameter int GRID_MAX = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp,
	input  wire logic        cfg_we,
	input  wire cfg_idx_t    cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int BD    = (DEPTH + 1) / 2;
	localparam int BW    = AW - 1;
	localparam int SW    = $clog2(GRID_MAX + 1);
	localparam int CELLW = $clog2(GRID_MAX);

	localparam logic signed [37:0] QMAX = 38'sd2147483647;
	localparam logic signed [37:0] QMIN = -38'sd2147483648;

	// configuration
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_z_q;
	logic [31:0]        inv_cell_q;
	logic [8:0]         side_q;
	logic [SW-1:0]      side_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			inv_cell_q <= INV_CELL_RST;
			side_q     <= SIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data;
				CFG_ORIGIN_Z: origin_z_q <= cfg_data;
				CFG_INV_CELL: inv_cell_q <= cfg_data;
				CFG_SIDE:     side_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (side_q < SIDE_MIN) begin
			side_e = SW'(2);
		end else if (32'(side_q) > 32'(GRID_MAX)) begin
			side_e = SW'(GRID_MAX);
		end else begin
			side_e = SW'(side_q);
		end
	end

	// pipeline advance
	logic adv;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	logic acc_in;
	assign acc_in = req_valid && adv;

	// stage 1: offset from origin
	logic               wr_s1, qry_s1;
	logic signed [32:0] rel_x_s1, rel_z_s1;
	logic [AW-1:0]      wa_s1;
	logic [HGT_W-1:0]   wd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1  <= 1'b0;
			qry_s1 <= 1'b0;
		end else if (adv) begin
			wr_s1  <= acc_in && (req.req_type == REQ_WRITE)
				&& (32'(req.vertex_index) < 32'(DEPTH));
			qry_s1 <= acc_in && (req.req_type == REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_x_s1 <= 33'(req.world_x) - 33'(origin_x_q);
			rel_z_s1 <= 33'(req.world_z) - 33'(origin_z_q);
			wa_s1    <= AW'(req.vertex_index);
			wd_s1    <= req.height_value;
		end
	end

	// stage 2: scale by reciprocal cell size
	logic             wr_s2, qry_s2;
	logic             neg_x_s2, neg_z_s2;
	logic [63:0]      prod_x_s2, prod_z_s2;
	logic [AW-1:0]    wa_s2;
	logic [HGT_W-1:0] wd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2  <= 1'b0;
			qry_s2 <= 1'b0;
		end else if (adv) begin
			wr_s2  <= wr_s1;
			qry_s2 <= qry_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_x_s2  <= rel_x_s1[32];
			neg_z_s2  <= rel_z_s1[32];
			prod_x_s2 <= 64'(rel_x_s1[31:0]) * 64'(inv_cell_q);
			prod_z_s2 <= 64'(rel_z_s1[31:0]) * 64'(inv_cell_q);
			wa_s2     <= wa_s1;
			wd_s2     <= wd_s1;
		end
	end

	// stage 3: cell index and fraction, grid bounds
	logic             wr_s3, qry_s3, miss_s3;
	logic [CELLW-1:0] cx_s3, cz_s3;
	logic [15:0]      fx_s3, fz_s3;
	logic [AW-1:0]    wa_s3;
	logic [HGT_W-1:0] wd_s3;
	logic [31:0]      cell_lim;

	assign cell_lim = 32'(side_e) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s3  <= 1'b0;
			qry_s3 <= 1'b0;
		end else if (adv) begin
			wr_s3  <= wr_s2;
			qry_s3 <= qry_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s3 <= neg_x_s2 || neg_z_s2 || (prod_x_s2[63:32] >= cell_lim)
				|| (prod_z_s2[63:32] >= cell_lim);
			cx_s3   <= prod_x_s2[32 +: CELLW];
			cz_s3   <= prod_z_s2[32 +: CELLW];
			fx_s3   <= prod_x_s2[31:16];
			fz_s3   <= prod_z_s2[31:16];
			wa_s3   <= wa_s2;
			wd_s3   <= wd_s2;
		end
	end

	// stage 4: corner addresses, triangle choice and weights
	logic [AW-1:0] base_c, base_up_c;
	logic [16:0]   fsum_c;
	logic          upper_c;

	assign base_c    = AW'(cz_s3) * AW'(side_e) + AW'(cx_s3);
	assign base_up_c = base_c + AW'(side_e);
	assign fsum_c    = 17'(fx_s3) + 17'(fz_s3);
	assign upper_c   = fsum_c > ONE_Q16;

	logic             wr_s4, qry_s4, miss_s4, upper_s4;
	logic             pa_s4, pb_s4;
	logic [BW-1:0]    ia_e_s4, ia_o_s4, ib_e_s4, ib_o_s4;
	logic [16:0]      wx_s4, wz_s4;
	logic [AW-1:0]    wa_s4;
	logic [HGT_W-1:0] wd_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s4  <= 1'b0;
			qry_s4 <= 1'b0;
		end else if (adv) begin
			wr_s4  <= wr_s3;
			qry_s4 <= qry_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s4  <= miss_s3;
			upper_s4 <= upper_c;
			pa_s4    <= base_c[0];
			pb_s4    <= base_up_c[0];
			ia_e_s4  <= base_c[AW-1:1] + BW'(base_c[0]);
			ia_o_s4  <= base_c[AW-1:1];
			ib_e_s4  <= base_up_c[AW-1:1] + BW'(base_up_c[0]);
			ib_o_s4  <= base_up_c[AW-1:1];
			wx_s4    <= upper_c ? ONE_Q16 - 17'(fx_s3) : 17'(fx_s3);
			wz_s4    <= upper_c ? ONE_Q16 - 17'(fz_s3) : 17'(fz_s3);
			wa_s4    <= wa_s3;
			wd_s4    <= wd_s3;
		end
	end

	// stage 5: bank writes and corner reads
	logic             we_e, we_o;
	logic [HGT_W-1:0] rd_ae, rd_ao, rd_be, rd_bo;

	assign we_e = wr_s4 && !wa_s4[0];
	assign we_o = wr_s4 && wa_s4[0];

	hbhq_ram #(.DEPTH(BD)) u_ram_ae (
		.clk(clk), .en(adv), .we(we_e), .waddr(wa_s4[AW-1:1]), .wdata(wd_s4),
		.raddr(ia_e_s4), .rdata(rd_ae)
	);

	hbhq_ram #(.DEPTH(BD)) u_ram_ao (
		.clk(clk), .en(adv), .we(we_o), .waddr(wa_s4[AW-1:1]), .wdata(wd_s4),
		.raddr(ia_o_s4), .rdata(rd_ao)
	);

	hbhq_ram #(.DEPTH(BD)) u_ram_be (
		.clk(clk), .en(adv), .we(we_e), .waddr(wa_s4[AW-1:1]), .wdata(wd_s4),
		.raddr(ib_e_s4), .rdata(rd_be)
	);

	hbhq_ram #(.DEPTH(BD)) u_ram_bo (
		.clk(clk), .en(adv), .we(we_o), .waddr(wa_s4[AW-1:1]), .wdata(wd_s4),
		.raddr(ib_o_s4), .rdata(rd_bo)
	);

	logic        qry_s5, miss_s5, upper_s5, pa_s5, pb_s5;
	logic [16:0] wx_s5, wz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_s5 <= 1'b0;
		end else if (adv) begin
			qry_s5 <= qry_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s5  <= miss_s4;
			upper_s5 <= upper_s4;
			pa_s5    <= pa_s4;
			pb_s5    <= pb_s4;
			wx_s5    <= wx_s4;
			wz_s5    <= wz_s4;
		end
	end

	// stage 6: corner select and edge differences
	logic signed [31:0] h00, h10, h01, h11;

	assign h00 = $signed(pa_s5 ? rd_ao : rd_ae);
	assign h10 = $signed(pa_s5 ? rd_ae : rd_ao);
	assign h01 = $signed(pb_s5 ? rd_bo : rd_be);
	assign h11 = $signed(pb_s5 ? rd_be : rd_bo);

	logic               qry_s6, miss_s6;
	logic signed [31:0] hb_s6;
	logic signed [32:0] d1_s6, d2_s6;
	logic [16:0]        wx_s6, wz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_s6 <= 1'b0;
		end else if (adv) begin
			qry_s6 <= qry_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s6 <= miss_s5;
			wx_s6   <= wx_s5;
			wz_s6   <= wz_s5;
			if (upper_s5) begin
				hb_s6 <= h11;
				d1_s6 <= 33'(h01) - 33'(h11);
				d2_s6 <= 33'(h10) - 33'(h11);
			end else begin
				hb_s6 <= h00;
				d1_s6 <= 33'(h10) - 33'(h00);
				d2_s6 <= 33'(h01) - 33'(h00);
			end
		end
	end

	// stage 7: weighted differences
	logic               qry_s7, miss_s7;
	logic signed [31:0] hb_s7;
	logic signed [50:0] p1_s7, p2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_s7 <= 1'b0;
		end else if (adv) begin
			qry_s7 <= qry_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s7 <= miss_s6;
			hb_s7   <= hb_s6;
			p1_s7   <= 51'($signed({1'b0, wx_s6})) * 51'(d1_s6);
			p2_s7   <= 51'($signed({1'b0, wz_s6})) * 51'(d2_s6);
		end
	end

	// stage 8: sum in Q.16
	logic               qry_s8, miss_s8;
	logic signed [52:0] acc_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_s8 <= 1'b0;
		end else if (adv) begin
			qry_s8 <= qry_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s8 <= miss_s7;
			acc_s8  <= (53'(hb_s7) <<< 16) + 53'(p1_s7) + 53'(p2_s7);
		end
	end

	// output: round half up, saturate
	logic signed [53:0] rnd_c;
	logic signed [37:0] q_c;
	logic signed [31:0] sat_c;

	assign rnd_c = 54'(acc_s8) + 54'sd32768;
	assign q_c   = 38'(rnd_c >>> 16);

	always_comb begin
		if (q_c > QMAX) begin
			sat_c = 32'(QMAX);
		end else if (q_c < QMIN) begin
			sat_c = 32'(QMIN);
		end else begin
			sat_c = 32'(q_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= qry_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.terrain_height <= miss_s8 ? '0 : sat_c;
			rsp_q.outside_grid   <= miss_s8;
		end
	end

endmodule

`default_nettype wire

@@ hdl/hbhq_checker.sv @@
// ----------------------------------------------------------------------------
// hbhq_checker
// Port-level checks of the heightmap barycentric height query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "heightmap_barycentric_height_query_assert.svh"

module hbhq_checker
	import hbhq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	logic req_take;
	assign req_take = req_valid && !req_stall && (req.req_type == REQ_QUERY);

	// held result keeps its payload
	`HBHQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

	// a miss carries height zero
	`HBHQ_ASSERT_IMPLY(a_miss_zero, clk, arst_n, rsp_valid && rsp.outside_grid, rsp.terrain_height == 32'sd0, "outside result with nonzero height")

	// request side stalls only behind a held result
	`HBHQ_ASSERT_IMPLY(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall, "request stall without held result")

	// a held result always backs up the request side
	`HBHQ_ASSERT_IMPLY(a_stall_prop, clk, arst_n, rsp_valid && rsp_stall, req_stall && !req_take, "request taken behind held result")

endmodule

bind heightmap_barycentric_height_query hbhq_checker u_hbhq_checker (.*);

`default_nettype wire
